// ===== rtl/core/pcsp_pkg.sv =====
// shared types and constants of the pixel control stream parser
package pcsp_pkg;

   localparam int unsigned PIXELS_PER_STRIP = 256;
   localparam int unsigned MAX_BODY_LENGTH  = 3 * PIXELS_PER_STRIP;
   localparam int unsigned MAX_CHANNEL      = 8;
   localparam int unsigned TRACK_MAX        = 15;

   localparam logic CMD_DATA    = 1'b0;
   localparam logic CMD_SESSION = 1'b1;

   typedef enum logic [1:0] {
      ERR_NONE    = 2'd0,
      ERR_OPCODE  = 2'd1,
      ERR_CHANNEL = 2'd2,
      ERR_LENGTH  = 2'd3
   } pcsp_error_type;

   typedef struct packed {
      logic       command;
      logic [7:0] data_byte;
   } pcsp_item_type;

   typedef struct packed {
      logic           pixel_write;
      logic [2:0]     strip_index;
      logic [7:0]     pixel_index;
      logic [7:0]     red;
      logic [7:0]     green;
      logic [7:0]     blue;
      logic           show;
      pcsp_error_type error_code;
   } pcsp_result_type;

endpackage

// ===== rtl/core/pcsp_parser.sv =====
// parser state and the per-word decode of header and body bytes
module pcsp_parser
   import pcsp_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            step,
   input  pcsp_item_type   item,
   output pcsp_result_type result
);

   typedef enum logic [2:0] {
      ST_CHANNEL,
      ST_OPCODE,
      ST_LEN_HIGH,
      ST_LEN_LOW,
      ST_BODY
   } parse_state_type;

   parse_state_type state_ff, state_in;
   logic [7:0]  channel_ff, channel_in;
   logic [7:0]  opcode_ff, opcode_in;
   logic [7:0]  length_high_ff, length_high_in;
   logic [15:0] body_length_ff, body_length_in;
   logic [15:0] body_count_ff, body_count_in;
   logic [1:0]  phase_ff, phase_in;
   logic [7:0]  triple_ff, triple_in;
   logic        discard_ff, discard_in;
   logic [3:0]  highest_ff, highest_in;
   logic        show_pending_ff, show_pending_in;
   logic [7:0]  held_red_ff, held_red_in;
   logic [7:0]  held_green_ff, held_green_in;

   logic [15:0] new_length;
   logic        opcode_bad;
   logic        channel_bad;
   logic        too_long;
   logic [7:0]  channel_fixed;
   logic [3:0]  channel_track;
   logic        body_end;

   assign new_length    = {length_high_ff, item.data_byte};
   assign opcode_bad    = (opcode_ff != 8'd0);
   assign channel_bad   = (channel_ff == 8'd0) || (channel_ff > 8'(MAX_CHANNEL));
   assign too_long      = (new_length > 16'(MAX_BODY_LENGTH));
   assign channel_fixed = (!opcode_bad && channel_bad) ? 8'd1 : channel_ff;
   assign channel_track = (channel_fixed > 8'(TRACK_MAX)) ? 4'(TRACK_MAX)
                                                          : channel_fixed[3:0];
   assign body_end      = ({1'b0, body_count_ff} + 17'd1) >= {1'b0, body_length_ff};

   always_comb begin
      state_in        = state_ff;
      channel_in      = channel_ff;
      opcode_in       = opcode_ff;
      length_high_in  = length_high_ff;
      body_length_in  = body_length_ff;
      body_count_in   = body_count_ff;
      phase_in        = phase_ff;
      triple_in       = triple_ff;
      discard_in      = discard_ff;
      highest_in      = highest_ff;
      show_pending_in = show_pending_ff;
      held_red_in     = held_red_ff;
      held_green_in   = held_green_ff;
      result          = '0;
      result.error_code = ERR_NONE;

      if (item.command == CMD_SESSION) begin
         // show_pending survives a new session
         state_in      = ST_CHANNEL;
         channel_in    = 8'd0;
         opcode_in     = 8'd0;
         length_high_in = 8'd0;
         body_length_in = 16'd0;
         body_count_in = 16'd0;
         phase_in      = 2'd0;
         triple_in     = 8'd0;
         discard_in    = 1'b0;
         highest_in    = 4'd0;
      end else begin
         unique case (state_ff)
            ST_CHANNEL: begin
               channel_in = item.data_byte;
               state_in   = ST_OPCODE;
            end
            ST_OPCODE: begin
               opcode_in = item.data_byte;
               state_in  = ST_LEN_HIGH;
            end
            ST_LEN_HIGH: begin
               length_high_in = item.data_byte;
               state_in       = ST_LEN_LOW;
            end
            ST_LEN_LOW: begin
               body_length_in = new_length;
               body_count_in  = 16'd0;
               phase_in       = 2'd0;
               triple_in      = 8'd0;
               channel_in     = channel_fixed;
               discard_in     = opcode_bad || channel_bad || too_long;
               if (opcode_bad) begin
                  result.error_code = ERR_OPCODE;
               end else if (channel_bad) begin
                  result.error_code = ERR_CHANNEL;
               end else if (too_long) begin
                  result.error_code = ERR_LENGTH;
               end
               // tracking runs for rejected headers too
               if (channel_fixed >= {4'd0, highest_ff}) begin
                  show_pending_in = 1'b1;
                  highest_in      = channel_track;
               end
               state_in = (new_length == 16'd0) ? ST_CHANNEL : ST_BODY;
            end
            ST_BODY: begin
               body_count_in = body_count_ff + 16'd1;
               phase_in      = (phase_ff == 2'd2) ? 2'd0 : phase_ff + 2'd1;
               if (phase_ff == 2'd2) begin
                  triple_in = triple_ff + 8'd1;
               end
               if (!discard_ff) begin
                  case (phase_ff)
                     2'd0:    held_red_in = item.data_byte;
                     2'd1:    held_green_in = item.data_byte;
                     default: begin
                        result.pixel_write = 1'b1;
                        result.strip_index = 3'(channel_ff - 8'd1);
                        result.pixel_index = triple_ff;
                        result.red         = held_red_ff;
                        result.green       = held_green_ff;
                        result.blue        = item.data_byte;
                     end
                  endcase
               end
               if (body_end) begin
                  if (!discard_ff && show_pending_ff) begin
                     result.show     = 1'b1;
                     show_pending_in = 1'b0;
                  end
                  state_in      = ST_CHANNEL;
                  body_count_in = 16'd0;
               end
            end
            default: state_in = ST_CHANNEL;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_CHANNEL;
         channel_ff      <= 8'd0;
         opcode_ff       <= 8'd0;
         length_high_ff  <= 8'd0;
         body_length_ff  <= 16'd0;
         body_count_ff   <= 16'd0;
         phase_ff        <= 2'd0;
         triple_ff       <= 8'd0;
         discard_ff      <= 1'b0;
         highest_ff      <= 4'd0;
         show_pending_ff <= 1'b0;
         held_red_ff     <= 8'd0;
         held_green_ff   <= 8'd0;
      end else if (step) begin
         state_ff        <= state_in;
         channel_ff      <= channel_in;
         opcode_ff       <= opcode_in;
         length_high_ff  <= length_high_in;
         body_length_ff  <= body_length_in;
         body_count_ff   <= body_count_in;
         phase_ff        <= phase_in;
         triple_ff       <= triple_in;
         discard_ff      <= discard_in;
         highest_ff      <= highest_in;
         show_pending_ff <= show_pending_in;
         held_red_ff     <= held_red_in;
         held_green_ff   <= held_green_in;
      end
   end

endmodule

// ===== rtl/core/pixel_control_stream_parser_top.sv =====
// Pixel control stream parser. Takes one stream word per cycle (a data byte or a
// session start) and gives exactly one result word for each: a pixel write for
// every complete color triple of an accepted message body, a show pulse at the
// end of an accepted body while a refresh is owed, and a header verdict on the
// word that completes a four-byte header. A word sits in an input register, is
// decoded by the combinational parser logic and lands in a result register, so
// throughput is one word per cycle as long as the result side keeps taking words;
// the input register frees up in the same cycle that the result register is
// emptied or loaded.
module pixel_control_stream_parser_top
   import pcsp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_command,
   input  logic [7:0] req_data_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_pixel_write,
   output logic [2:0] rsp_strip_index,
   output logic [7:0] rsp_pixel_index,
   output logic [7:0] rsp_red,
   output logic [7:0] rsp_green,
   output logic [7:0] rsp_blue,
   output logic       rsp_show,
   output logic [1:0] rsp_error_code
);

   logic            in_valid_ff, in_valid_in;
   pcsp_item_type   in_item_ff;
   logic            out_valid_ff, out_valid_in;
   pcsp_result_type out_result_ff;
   pcsp_result_type result;
   logic            advance;
   logic            req_take;

   // a buffered word moves on when the result register is empty or draining
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   pcsp_parser u_parser (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (in_item_ff),
      .result (result)
   );

   always_comb begin
      in_valid_in  = req_take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      out_valid_in = advance ? 1'b1 : (rsp_ready ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff.command   <= req_command;
         in_item_ff.data_byte <= req_data_byte;
      end
      if (advance) begin
         out_result_ff <= result;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_pixel_write = out_result_ff.pixel_write;
   assign rsp_strip_index = out_result_ff.strip_index;
   assign rsp_pixel_index = out_result_ff.pixel_index;
   assign rsp_red         = out_result_ff.red;
   assign rsp_green       = out_result_ff.green;
   assign rsp_blue        = out_result_ff.blue;
   assign rsp_show        = out_result_ff.show;
   assign rsp_error_code  = out_result_ff.error_code;

   // a verdict only comes with a header word, never with body output
   a_verdict_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_error_code != ERR_NONE) |-> !rsp_pixel_write && !rsp_show)
      else $error("header verdict together with body output");

   // a session start always yields an empty result word
   a_session_empty: assert property (@(posedge clock) disable iff (reset)
      advance && (in_item_ff.command == CMD_SESSION) |=>
         rsp_valid && !rsp_pixel_write && !rsp_show && (rsp_error_code == ERR_NONE))
      else $error("session start gave a non-empty result");

   // each decoded word lands in the result register on the next edge
   a_advance_loads: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid)
      else $error("decoded word lost");

   a_reset_empty: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid && req_ready)
      else $error("pipeline not empty after reset");

endmodule

// ===== sim/tb_pixel_control_stream_parser_top.sv =====
// self-checking testbench for the pixel control stream parser top level
module tb_pixel_control_stream_parser_top;
   import pcsp_pkg::*;

   localparam int unsigned CYCLE_LIMIT  = 400000;
   localparam int unsigned HEADER_BYTES = 4;
   localparam int unsigned TRIPLE_BYTES = 3;
   localparam int unsigned RANDOM_WORDS = 350;
   localparam int unsigned IDLE_PERCENT = 36;
   localparam int unsigned DRAIN_CYCLES = 10;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic       req_command = CMD_DATA;
   logic [7:0] req_data_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic       rsp_pixel_write;
   logic [2:0] rsp_strip_index;
   logic [7:0] rsp_pixel_index;
   logic [7:0] rsp_red;
   logic [7:0] rsp_green;
   logic [7:0] rsp_blue;
   logic       rsp_show;
   logic [1:0] rsp_error_code;

   // mirror of the parser state
   logic [2:0]  hdr_count = '0;
   logic [7:0]  chan_byte = '0;
   logic [7:0]  op_byte = '0;
   logic [7:0]  len_high = '0;
   logic [15:0] body_len = '0;
   logic [15:0] body_pos = '0;
   logic        swallowing = 1'b0;
   logic [3:0]  top_channel = '0;
   logic        show_owed = 1'b0;
   logic [7:0]  red_hold = '0;
   logic [7:0]  green_hold = '0;

   pcsp_result_type expected_words[$];
   int unsigned     error_count = 0;
   int unsigned     cycle_count = 0;
   int unsigned     words_sent = 0;
   bit              steady = 1'b0;

   pixel_control_stream_parser_top dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_command     (req_command),
      .req_data_byte   (req_data_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_pixel_write (rsp_pixel_write),
      .rsp_strip_index (rsp_strip_index),
      .rsp_pixel_index (rsp_pixel_index),
      .rsp_red         (rsp_red),
      .rsp_green       (rsp_green),
      .rsp_blue        (rsp_blue),
      .rsp_show        (rsp_show),
      .rsp_error_code  (rsp_error_code)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
      end
   end

   function automatic pcsp_result_type parse_word(input logic cmd, input logic [7:0] b);
      pcsp_result_type r;
      logic [15:0]     pos;
      r = '0;
      if (cmd == CMD_SESSION) begin
         // pending show survives a new session
         hdr_count   = '0;
         chan_byte   = '0;
         op_byte     = '0;
         len_high    = '0;
         body_len    = '0;
         body_pos    = '0;
         swallowing  = 1'b0;
         red_hold    = '0;
         green_hold  = '0;
         top_channel = '0;
         return r;
      end
      if (hdr_count < HEADER_BYTES) begin
         case (hdr_count)
            3'd0: begin
               chan_byte = b;
               hdr_count = 3'd1;
            end
            3'd1: begin
               op_byte   = b;
               hdr_count = 3'd2;
            end
            3'd2: begin
               len_high  = b;
               hdr_count = 3'd3;
            end
            default: begin
               body_len   = {len_high, b};
               body_pos   = '0;
               swallowing = 1'b1;
               if (op_byte != 8'd0) begin
                  r.error_code = ERR_OPCODE;
               end else if (chan_byte < 1 || chan_byte > MAX_CHANNEL) begin
                  r.error_code = ERR_CHANNEL;
                  chan_byte    = 8'd1;
               end else if (body_len > MAX_BODY_LENGTH) begin
                  r.error_code = ERR_LENGTH;
               end else begin
                  swallowing = 1'b0;
               end
               // rejected headers still move the tracked channel
               if (chan_byte >= top_channel) begin
                  show_owed   = 1'b1;
                  top_channel = (chan_byte > TRACK_MAX) ? 4'(TRACK_MAX) : chan_byte[3:0];
               end
               hdr_count = (body_len == 16'd0) ? 3'd0 : 3'(HEADER_BYTES);
            end
         endcase
         return r;
      end
      pos      = body_pos;
      body_pos = body_pos + 16'd1;
      if (!swallowing) begin
         case (pos % TRIPLE_BYTES)
            0: red_hold = b;
            1: green_hold = b;
            default: begin
               r.pixel_write = 1'b1;
               r.strip_index = 3'(chan_byte - 8'd1);
               r.pixel_index = 8'(pos / TRIPLE_BYTES);
               r.red         = red_hold;
               r.green       = green_hold;
               r.blue        = b;
            end
         endcase
      end
      if (32'(pos) + 1 >= 32'(body_len)) begin
         if (!swallowing && show_owed) begin
            r.show    = 1'b1;
            show_owed = 1'b0;
         end
         hdr_count = '0;
         body_pos  = '0;
      end
      return r;
   endfunction

   function automatic void check_field(input string field, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
         error_count++;
      end
   endfunction

   // outputs are stable at the falling edge, the word moves at the next rising edge
   always @(negedge clock) begin
      pcsp_result_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (expected_words.size() == 0) begin
            $display("%0t: result word expected none actual write=%0b show=%0b err=%0d",
                     $time, rsp_pixel_write, rsp_show, rsp_error_code);
            error_count++;
         end else begin
            want = expected_words.pop_front();
            check_field("pixel_write", want.pixel_write, rsp_pixel_write);
            check_field("strip_index", want.strip_index, rsp_strip_index);
            check_field("pixel_index", want.pixel_index, rsp_pixel_index);
            check_field("red", want.red, rsp_red);
            check_field("green", want.green, rsp_green);
            check_field("blue", want.blue, rsp_blue);
            check_field("show", want.show, rsp_show);
            check_field("error_code", want.error_code, rsp_error_code);
         end
      end
   end

   task automatic send_word(input logic cmd, input logic [7:0] b);
      bit taken;
      while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_command   <= cmd;
      req_data_byte <= b;
      do begin
         @(negedge clock);
         taken = req_ready;
         @(posedge clock);
      end while (!taken);
      expected_words.push_back(parse_word(cmd, b));
      words_sent++;
   endtask

   // header then random body bytes, cut off after word_count words
   task automatic send_message(input logic [7:0] chan, input logic [7:0] op,
                               input logic [15:0] len, input int unsigned word_count);
      logic [31:0] hdr;
      int unsigned i;
      hdr = {chan, op, len};
      for (i = 0; i < word_count; i++) begin
         if (i < HEADER_BYTES) begin
            send_word(CMD_DATA, hdr[31 - 8 * i -: 8]);
         end else begin
            send_word(CMD_DATA, 8'($urandom));
         end
      end
   endtask

   task automatic send_random_message();
      int unsigned roll;
      int unsigned len;
      int unsigned words;
      logic [7:0]  chan;
      logic [7:0]  op;
      roll = $urandom_range(99);
      if (roll < 80) begin
         chan = 8'($urandom_range(MAX_CHANNEL, 1));
      end else if (roll < 88) begin
         chan = 8'd0;
      end else begin
         chan = 8'($urandom_range(255, MAX_CHANNEL + 1));
      end
      op = ($urandom_range(99) < 88) ? 8'd0 : 8'($urandom_range(255, 1));
      roll = $urandom_range(99);
      if (roll < 60) begin
         len = $urandom_range(24);
      end else if (roll < 80) begin
         len = TRIPLE_BYTES * $urandom_range(30);
      end else if (roll < 93) begin
         len = $urandom_range(120, 25);
      end else if (roll < 97) begin
         len = $urandom_range(MAX_BODY_LENGTH, 121);
      end else begin
         len = $urandom_range(16'hFFFF, MAX_BODY_LENGTH + 1);
      end
      // oversize and broken messages end early with a new session
      if (len > MAX_BODY_LENGTH || $urandom_range(99) < 6) begin
         words = $urandom_range(HEADER_BYTES + (len < 12 ? len : 12), 1);
         send_message(chan, op, 16'(len), words);
         send_word(CMD_SESSION, 8'($urandom));
      end else begin
         send_message(chan, op, 16'(len), HEADER_BYTES + len);
      end
   endtask

   task automatic test_header_cases();
      send_word(CMD_SESSION, 8'hFF);
      // zero length: ends on the header, no show
      send_message(8'd1, 8'd0, 16'd0, HEADER_BYTES);
      // one triple and a trailing partial triple, show at the end
      send_message(8'd8, 8'd0, 16'd4, HEADER_BYTES);
      send_word(CMD_DATA, 8'hFF);
      send_word(CMD_DATA, 8'h00);
      send_word(CMD_DATA, 8'hFF);
      send_word(CMD_DATA, 8'h7F);
      // bad opcode beats bad channel and length, wide channel clamps tracking
      send_message(8'hFF, 8'hFF, 16'hFFFF, HEADER_BYTES);
      send_word(CMD_SESSION, 8'h00);
      // bad channel forced to one
      send_message(8'd0, 8'd0, 16'd0, HEADER_BYTES);
      // one byte over the limit
      send_message(8'd2, 8'd0, 16'(MAX_BODY_LENGTH + 1), HEADER_BYTES);
      send_word(CMD_SESSION, 8'h5A);
   endtask

   task automatic test_full_strip();
      send_word(CMD_SESSION, 8'($urandom));
      send_message(8'($urandom_range(MAX_CHANNEL, 1)), 8'd0, 16'(MAX_BODY_LENGTH),
                   HEADER_BYTES + MAX_BODY_LENGTH);
      // rejected body swallowed to its end
      send_message(8'd5, 8'd1, 16'd60, HEADER_BYTES + 60);
      send_message(8'd5, 8'd0, 16'd3, HEADER_BYTES + 3);
   endtask

   task automatic test_back_to_back();
      steady = 1'b1;
      send_word(CMD_SESSION, 8'($urandom));
      repeat (8) send_random_message();
      steady = 1'b0;
   endtask

   task automatic test_random_stream();
      int unsigned start;
      int unsigned roll;
      start = words_sent;
      while (words_sent - start < RANDOM_WORDS) begin
         roll = $urandom_range(99);
         if (roll < 5) begin
            send_word(CMD_SESSION, 8'($urandom));
         end else if (roll < 9) begin
            repeat ($urandom_range(6, 1)) send_word(CMD_DATA, 8'($urandom));
            send_word(CMD_SESSION, 8'($urandom));
         end else begin
            send_random_message();
         end
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_header_cases();
      test_full_strip();
      test_back_to_back();
      test_random_stream();
      req_valid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/pcsp_pkg.sv
rtl/core/pcsp_parser.sv
rtl/core/pixel_control_stream_parser_top.sv
sim/tb_pixel_control_stream_parser_top.sv
